@@ rtl/incremental_linear_interpolator_defines.svh @@
// Assertion macros shared by the interpolator RTL.
`ifndef INCREMENTAL_LINEAR_INTERPOLATOR_DEFINES_SVH
`define INCREMENTAL_LINEAR_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low
`define ILI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ili: implication check failed");

// Next-cycle implication, disabled while reset is low
`define ILI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ili: next-cycle check failed");

`else

`define ILI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ILI_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ili_pkg.sv @@
// Shared types and constants of the incremental linear interpolator.
package ili_pkg;

  // Default span field width
  localparam int unsigned COORD_WIDTH_DEF = 16;
  // Width of the running value
  localparam int unsigned VALUE_WIDTH = 32;

  // Request kinds carried on the input tuser
  localparam logic REQ_INIT = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Operation of the shared add/subtract unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Kind of the item held by the sequencer
  typedef enum logic [1:0] {
    K_INIT,
    K_STEP,
    K_ERR
  } kind_e;

endpackage

@@ rtl/ili_alu.sv @@
// Shared add/subtract unit used by every multiply, divide and step cycle.
module ili_alu #(
  parameter int unsigned WIDTH = 18
) (
  input  ili_pkg::alu_op_e   op_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic [WIDTH-1:0]   y_o,
  output logic               carry_o  // add: carry out; sub: 1 when a_i >= b_i
);

  logic             is_sub;
  logic [WIDTH-1:0] b_eff;

  // Subtract as a + ~b + 1
  assign is_sub = (op_i == ili_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~b_i : b_i;
  assign {carry_o, y_o} = {1'b0, a_i} + {1'b0, b_eff} + (WIDTH + 1)'(is_sub);

endmodule

@@ rtl/incremental_linear_interpolator.sv @@
// Top level of the incremental linear interpolator (integer DDA).
//
// Input stream: s_axis_tuser selects init (0) or step (1); s_axis_tdata
// holds the five span fields. Every transfer in gives one transfer out on
// m_axis with the running value and an error flag.
// Init runs |b-1-a| * |f-d| through a shift-add multiplier and then a
// restoring divider by |c-a|, both on one shared add/subtract unit, one bit
// per cycle. A step adds the value magnitude to the remainder; when the sum
// is not negative it divides it by the screen magnitude. A refused item
// (empty screen span, step before init) goes straight to the finish state.
// s_axis_tready is high only while no item is in work; one item at a time.
// The result sits in an output register; while the receiver stalls the
// sequencer holds the finished item, and a new item is taken once it left.
// Reset clears the running value, the stored span state and the init flag.
module incremental_linear_interpolator #(
  parameter int unsigned COORD_WIDTH = ili_pkg::COORD_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // span_start, start_position, span_end, value_start, value_end
  input  logic [((5 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // req_type
  input  logic                                         s_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // current_value
  output logic [ili_pkg::VALUE_WIDTH-1:0]              m_axis_tdata,
  // error
  output logic                                         m_axis_tuser
);

  `include "incremental_linear_interpolator_defines.svh"

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned MW = W + 1;             // magnitude width
  localparam int unsigned PW = 2 * MW;            // product / dividend width
  localparam int unsigned AW = MW + 1;            // shared unit and remainder width
  localparam int unsigned VW = ili_pkg::VALUE_WIDTH;
  localparam int unsigned QW = (PW > VW) ? PW : VW;
  localparam int unsigned CW = $clog2(PW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_q;
  ili_pkg::kind_e      kind_q;
  logic [CW-1:0]       cnt_q;
  logic [PW-1:0]       x_q;
  logic [MW-1:0]       r_q;
  logic [W-1:0]        d_q;
  logic                q_neg_q;
  logic                off_neg_q;
  logic                div_used_q;

  // Stored interpolator state
  logic [VW-1:0]       run_q;
  logic [AW-1:0]       rem_q;
  logic [MW-1:0]       vm_q;
  logic [MW-1:0]       sm_q;
  logic                step_neg_q;
  logic                init_q;

  logic                out_valid_q;
  logic                out_valid_d;
  logic [VW-1:0]       out_value_q;
  logic                out_err_q;

  // Input fields
  logic [W-1:0]        a_in, b_in, c_in, d_in, f_in;
  logic [W:0]          ca_w, fd_w;
  logic [AW-1:0]       off_w, off_abs;
  logic                ca_neg, fd_neg, off_neg, ca_zero;
  logic [W:0]          ca_abs, fd_abs;
  logic                in_fire, req_step;

  // Shared unit
  ili_pkg::alu_op_e    alu_op;
  logic [AW-1:0]       alu_a, alu_b, alu_y;
  logic                alu_carry;

  // Finish values
  logic [QW-1:0]       q_ext, q_sgn;
  logic [VW-1:0]       d_ext, n_ext, init_run, step_run, fin_value;
  logic [AW-1:0]       rem_pos, init_rem;
  logic                fin_load;

  assign a_in = s_axis_tdata[W-1:0];
  assign b_in = s_axis_tdata[2*W-1:W];
  assign c_in = s_axis_tdata[3*W-1:2*W];
  assign d_in = s_axis_tdata[4*W-1:3*W];
  assign f_in = s_axis_tdata[5*W-1:4*W];

  // Span differences and their magnitudes
  assign ca_w    = {c_in[W-1], c_in} - {a_in[W-1], a_in};
  assign fd_w    = {f_in[W-1], f_in} - {d_in[W-1], d_in};
  assign off_w   = {{2{b_in[W-1]}}, b_in} - {{2{a_in[W-1]}}, a_in} - AW'(1);
  assign ca_neg  = ca_w[W];
  assign fd_neg  = fd_w[W];
  assign off_neg = off_w[AW-1];
  assign ca_abs  = ca_neg ? -ca_w : ca_w;
  assign fd_abs  = fd_neg ? -fd_w : fd_w;
  assign off_abs = off_neg ? -off_w : off_w;
  assign ca_zero = (ca_w == '0);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign req_step      = (s_axis_tuser == ili_pkg::REQ_STEP);

  // Operand select for the shared unit
  always_comb begin
    alu_op = ili_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      S_MUL: begin
        alu_a = {1'b0, x_q[PW-1:MW]};
        alu_b = x_q[0] ? {1'b0, vm_q} : '0;
      end
      S_DIV: begin
        alu_op = ili_pkg::ALU_SUB;
        alu_a  = {r_q, x_q[PW-1]};
        alu_b  = {1'b0, sm_q};
      end
      S_ADD: begin
        alu_a = rem_q;
        alu_b = {1'b0, vm_q};
      end
      default: ;
    endcase
  end

  ili_alu #(
    .WIDTH (AW)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .y_o     (alu_y),
    .carry_o (alu_carry)
  );

  // Result of an init: d + signed quotient, remainder with the sign of the offset
  assign q_ext    = QW'(x_q);
  assign q_sgn    = q_neg_q ? -q_ext : q_ext;
  assign d_ext    = {{(VW - W){d_q[W-1]}}, d_q};
  assign init_run = d_ext + q_sgn[VW-1:0];
  assign rem_pos  = {1'b0, r_q};
  assign init_rem = off_neg_q ? -rem_pos : rem_pos;

  // Result of a step: move by the whole screen magnitudes held
  assign n_ext    = {{(VW - MW){1'b0}}, x_q[MW-1:0]};
  assign step_run = step_neg_q ? (run_q - n_ext) : (run_q + n_ext);

  always_comb begin
    case (kind_q)
      ili_pkg::K_INIT: fin_value = init_run;
      ili_pkg::K_STEP: fin_value = step_run;
      default:         fin_value = run_q;
    endcase
  end

  assign fin_load    = (state_q == S_FIN) & (~out_valid_q | m_axis_tready);
  assign out_valid_d = fin_load | (out_valid_q & ~m_axis_tready);

  // Sequencer and stored state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      init_q      <= 1'b0;
      run_q       <= '0;
      rem_q       <= '0;
      vm_q        <= '0;
      sm_q        <= '0;
      step_neg_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (!req_step) begin
              if (ca_zero) begin
                state_q <= S_FIN;
              end else begin
                vm_q       <= fd_abs;
                sm_q       <= ca_abs;
                step_neg_q <= fd_neg ^ ca_neg;
                state_q    <= S_MUL;
              end
            end else if (!init_q) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_ADD;
            end
          end
        end
        S_MUL: begin
          if (cnt_q == '0) state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) state_q <= S_FIN;
        end
        S_ADD: begin
          // negative sum: no movement, keep the sum as remainder
          if (alu_y[AW-1]) begin
            rem_q   <= alu_y;
            state_q <= S_FIN;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state_q <= S_IDLE;
            case (kind_q)
              ili_pkg::K_INIT: begin
                run_q  <= init_run;
                rem_q  <= init_rem;
                init_q <= 1'b1;
              end
              ili_pkg::K_STEP: begin
                run_q <= step_run;
                if (div_used_q) rem_q <= rem_pos;
              end
              default: ;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Work registers of the multiply and divide iterations
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (req_step) begin
            kind_q <= init_q ? ili_pkg::K_STEP : ili_pkg::K_ERR;
          end else begin
            kind_q <= ca_zero ? ili_pkg::K_ERR : ili_pkg::K_INIT;
          end
          x_q       <= {{MW{1'b0}}, off_abs[MW-1:0]};
          cnt_q     <= CW'(MW - 1);
          d_q       <= d_in;
          off_neg_q <= off_neg;
          q_neg_q   <= off_neg ^ fd_neg ^ ca_neg;
        end
      end
      S_MUL: begin
        // right-shift multiply: add multiplicand when the low bit is set
        x_q <= {alu_y, x_q[MW-1:1]};
        if (cnt_q == '0) begin
          r_q   <= '0;
          cnt_q <= CW'(PW - 1);
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      S_DIV: begin
        // restoring divide: one quotient bit per cycle
        x_q <= {x_q[PW-2:0], alu_carry};
        r_q <= alu_carry ? alu_y[MW-1:0] : {r_q[MW-2:0], x_q[PW-1]};
        if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
      end
      S_ADD: begin
        if (alu_y[AW-1]) begin
          x_q        <= '0;
          div_used_q <= 1'b0;
        end else begin
          x_q        <= {alu_y[MW-1:0], {MW{1'b0}}};
          r_q        <= '0;
          cnt_q      <= CW'(MW - 1);
          div_used_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_value_q <= fin_value;
      out_err_q   <= (kind_q == ili_pkg::K_ERR);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_err_q;

  // Checks
  `ILI_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !s_axis_tready)
  `ILI_ASSERT_IMP(a_div_rem_below_divisor, clk_i, rst_ni, state_q == S_DIV, r_q < sm_q)
  `ILI_ASSERT_IMP(a_mul_only_for_init, clk_i, rst_ni, state_q == S_MUL, kind_q == ili_pkg::K_INIT)
  `ILI_ASSERT_NXT(a_early_step_refused, clk_i, rst_ni, in_fire && req_step && !init_q, state_q == S_FIN && kind_q == ili_pkg::K_ERR)

endmodule
